/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of the palette fade block.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define PDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication that must hold in the next cycle.
`define PDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pdf_pkg.sv */
// Package for the palette damage fade block: item mode codes, limits and
// the step and divide helpers. Depends on nothing.
package pdf_pkg;

  localparam logic [2:0] MODE_COLOR    = 3'd0;
  localparam logic [2:0] MODE_FRAME    = 3'd1;
  localparam logic [2:0] MODE_PAIN_ADD = 3'd2;
  localparam logic [2:0] MODE_PAIN_CLR = 3'd3;
  localparam logic [2:0] MODE_FADE_SET = 3'd4;

  localparam logic [1:0] KIND_HOLD   = 2'd0;
  localparam logic [1:0] KIND_DEEPEN = 2'd1;

  localparam logic [6:0] STEP_FULL       = 7'd120;
  localparam logic [5:0] COMP_MAX        = 6'd63;
  localparam logic [3:0] PAIN_MAX        = 4'd10;
  localparam logic [3:0] FADE_DEEPEN_MAX = 4'd12;

  // Fade step for a pain level and a fade level, 0 to 120.
  function automatic logic [6:0] step_of(input logic [3:0] p, input logic [3:0] f);
    logic [8:0] ip;
    logic [8:0] ifd;
    logic [8:0] isum;
    begin
      ip   = (p != 4'd0) ? 9'd12 * 9'(p - 4'd1) : 9'd0;
      ifd  = (f != 4'd0) ? 9'd10 * 9'(f - 4'd1) : 9'd0;
      isum = ip + ifd;
      if (isum >= 9'(STEP_FULL)) begin
        step_of = 7'd0;
      end else begin
        step_of = STEP_FULL - isum[6:0];
      end
    end
  endfunction

  // Quotient of x by 120, saturated at 63. Below the saturation point the
  // value is divided by 8 with a shift and by 15 with a reciprocal multiply
  // by 4370 / 65536, which is exact for inputs under 960.
  function automatic logic [5:0] div120_sat(input logic [14:0] x);
    logic [9:0]  y;
    logic [22:0] acc;
    begin
      y   = x[12:3];
      acc = {1'b0, y, 12'b0} + {5'b0, y, 8'b0} + {9'b0, y, 4'b0} + {12'b0, y, 1'b0};
      if (x >= 15'd7680) begin
        div120_sat = COMP_MAX;
      end else begin
        div120_sat = acc[21:16];
      end
    end
  endfunction

endpackage

/* hw/rtl/palette_damage_fade.sv */
// Palette damage fade: pain and fade level state plus the colour datapath.
// Depends on pdf_pkg.
//
// Usage: items arrive on the input channel (in_valid / in_stall) and each
// gives exactly one result on the output channel (out_valid / out_stall).
// A colour item returns the faded colour while fade is active and zero colour
// otherwise; the other modes update the pain and fade levels and return zero
// colour. fade_active and fade_step always report the state as it stood before
// the item. The result is registered when the item is accepted. One item is
// accepted every cycle while the input is not stalled; the fade step is kept
// in a register next to the levels, so the colour path is one 7x8 multiply,
// a constant reciprocal multiply and a clamp before the result register.
// The input side stalls only while a result is held and the receiver
// stalls, and a new item is taken in the same cycle the held one leaves.
// Reset clears both levels, so the block reports no fade until pain is
// added or a fade level is set, and drops any result not yet taken.
module palette_damage_fade (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       mode,
  input  logic [7:0]       red_in,
  input  logic [7:0]       green_in,
  input  logic [7:0]       blue_in,
  input  logic signed [7:0] pain_amount,
  input  logic [1:0]       effect_kind,
  input  logic [3:0]       fade_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [5:0]       red_out,
  output logic [5:0]       green_out,
  output logic [5:0]       blue_out,
  output logic             fade_active,
  output logic [6:0]       fade_step
);
  import pdf_pkg::*;

  logic [3:0] pain_level;
  logic [3:0] pain_level_next;
  logic [3:0] fade_level;
  logic [3:0] fade_level_next;
  logic       active;
  logic [6:0] step;
  logic       accept;

  logic signed [9:0] pain_sum;
  logic [14:0]       red_prod;
  logic [14:0]       green_prod;
  logic [14:0]       blue_prod;
  logic [5:0]        red_calc;
  logic [5:0]        red_val;
  logic [5:0]        green_val;
  logic [5:0]        blue_val;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pain_sum = $signed({6'b0, pain_level}) + 10'(pain_amount);

  always_comb begin
    pain_level_next = pain_level;
    fade_level_next = fade_level;
    case (mode)
      MODE_FRAME: begin
        if (pain_level != 4'd0) begin
          pain_level_next = pain_level - 4'd1;
        end
        if (fade_level != 4'd0 && effect_kind != KIND_HOLD) begin
          if (effect_kind == KIND_DEEPEN) begin
            if (fade_level <= FADE_DEEPEN_MAX) begin
              fade_level_next = fade_level + 4'd1;
            end
          end else begin
            fade_level_next = fade_level - 4'd1;
          end
        end
      end
      MODE_PAIN_ADD: begin
        if (pain_sum < 10'sd1) begin
          pain_level_next = 4'd1;
        end else if (pain_sum > 10'sd10) begin
          pain_level_next = PAIN_MAX;
        end else begin
          pain_level_next = pain_sum[3:0];
        end
      end
      MODE_PAIN_CLR: begin
        pain_level_next = 4'd0;
      end
      MODE_FADE_SET: begin
        fade_level_next = fade_value;
      end
      default: begin
      end
    endcase
  end

  // Red is pulled toward 63: a source at or above 63 stays at 63, below it
  // the distance to 63 is scaled by step/120 (truncated) and taken off 63.
  assign red_prod   = {8'b0, step} * {9'b0, COMP_MAX - red_in[5:0]};
  assign green_prod = {8'b0, step} * {7'b0, green_in};
  assign blue_prod  = {8'b0, step} * {7'b0, blue_in};
  assign red_calc   = COMP_MAX - div120_sat(red_prod);
  assign red_val    = (red_in >= 8'(COMP_MAX)) ? COMP_MAX : red_calc;
  assign green_val  = div120_sat(green_prod);
  assign blue_val   = div120_sat(blue_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      pain_level <= 4'd0;
      fade_level <= 4'd0;
      active     <= 1'b0;
      step       <= 7'd0;
    end else if (accept) begin
      pain_level <= pain_level_next;
      fade_level <= fade_level_next;
      active     <= (pain_level_next != 4'd0) || (fade_level_next != 4'd0);
      step       <= ((pain_level_next != 4'd0) || (fade_level_next != 4'd0))
                    ? step_of(pain_level_next, fade_level_next) : 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fade_active <= active;
      fade_step   <= step;
      if (mode == MODE_COLOR && active) begin
        red_out   <= red_val;
        green_out <= green_val;
        blue_out  <= blue_val;
      end else begin
        red_out   <= 6'd0;
        green_out <= 6'd0;
        blue_out  <= 6'd0;
      end
    end
  end

endmodule

/* hw/rtl/pdf_checker.sv */
// Port-level checker for palette_damage_fade, attached by bind.
// Depends on pdf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pdf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [2:0]        mode,
  input logic [7:0]        red_in,
  input logic [7:0]        green_in,
  input logic [7:0]        blue_in,
  input logic signed [7:0] pain_amount,
  input logic [1:0]        effect_kind,
  input logic [3:0]        fade_value,
  input logic              out_valid,
  input logic              out_stall,
  input logic [5:0]        red_out,
  input logic [5:0]        green_out,
  input logic [5:0]        blue_out,
  input logic              fade_active,
  input logic [6:0]        fade_step
);
  import pdf_pkg::*;

  // A held result stays valid and unchanged while the receiver stalls.
  `PDF_ASSERT_NEXT(a_hold, out_valid && out_stall,
                   out_valid && $stable(red_out) && $stable(green_out)
                   && $stable(blue_out) && $stable(fade_step),
                   "held result changed while stalled")

  // Every accepted item shows a result at the next edge.
  `PDF_ASSERT_NEXT(a_result, in_valid && !in_stall, out_valid, "accepted item gave no result")

  // Without fade the block reports a zero step and no colour.
  `PDF_ASSERT_NOW(a_idle, out_valid && !fade_active,
                  fade_step == 7'd0 && red_out == 6'd0 && green_out == 6'd0
                  && blue_out == 6'd0,
                  "inactive result not zero")

  // The step never exceeds its full value.
  `PDF_ASSERT_NOW(a_range, out_valid, fade_step <= STEP_FULL, "fade step out of range")

endmodule

bind palette_damage_fade pdf_checker u_pdf_checker (.*);
